// File: hdl/bhs_pkg.sv
`timescale 1ns / 1ps
// Shared types and operation codes for the bucketed hash set.
package bhs_pkg;

    // Operation codes carried on the mode port.
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    // Control sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_UPDATE,
        ST_CLEAR
    } state_t;

    // Width of the key port and of the stored-count port.
    localparam int unsigned KEY_PORT_W = 32;
    localparam int unsigned COUNT_W    = 8;

endpackage : bhs_pkg

// File: hdl/bhs_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
module bhs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : bhs_ram

// File: hdl/bucketed_hash_set_unit.sv
`timescale 1ns / 1ps
// Top level of the bucketed hash set: sequencer, bucket hashing and row update.
//
// A set of keys held in BUCKETS fixed buckets of SLOTS_PER_BUCKET slots each.
// Each transaction is one operation (insert, delete, lookup or clear all) and
// gives exactly one result, shown for a single cycle with done high; the
// receiver cannot stall, so results must be taken as they appear. A new
// operation is accepted on a rising edge with start high and busy low.
// When BUCKETS is a power of two the bucket is the key's low bits and an
// insert, delete or lookup reads the bucket row from the slot memories as
// it is accepted, then compares every slot in parallel and writes the row
// back. Otherwise the key is first multiplied by a fixed reciprocal of
// BUCKETS to get the quotient, and the remainder is formed as the row is
// read, before the compare and write-back. The clearing pass that runs
// after reset sweeps the valid memory one bucket row per cycle, and no
// operation is accepted until it ends; clear all runs the same sweep.
// Only the low min(KEY_BITS, 32) bits of the key take part.
// An insert into a bucket with no free slot is refused and flagged on
// full_res. stored_count wraps modulo 256 if the table can hold more keys.
module bucketed_hash_set_unit #(
    parameter int unsigned BUCKETS          = 16,
    parameter int unsigned SLOTS_PER_BUCKET = 8,
    parameter int unsigned KEY_BITS         = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         mode,
    input  logic [bhs_pkg::KEY_PORT_W-1:0]     key,
    output logic                               done,
    output logic                               hit,
    output logic                               full_res,
    output logic [bhs_pkg::COUNT_W-1:0]        stored_count
);

    import bhs_pkg::*;

    // Effective key width: the key port carries at most 32 bits.
    localparam int unsigned KW      = (KEY_BITS < KEY_PORT_W) ? KEY_BITS : KEY_PORT_W;
    localparam int unsigned BW      = $clog2(BUCKETS);
    localparam int unsigned SLOTS   = SLOTS_PER_BUCKET;
    localparam bit          IS_POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [KEY_PORT_W-1:0] KEY_MASK =
        KEY_PORT_W'(({1'b0, {KEY_PORT_W{1'b0}}} | (33'd1 << KW)) - 33'd1);
    localparam logic [BW-1:0] LAST_ROW    = BW'(BUCKETS - 1);
    // The reciprocal is rounded up with KW + BW fraction bits, which makes the
    // quotient exact for every key of KW bits.
    localparam int unsigned   QSH   = KW + BW;
    localparam int unsigned   PW    = 2 * KW + 1;
    localparam logic [63:0]   RECIP = ((64'd1 << QSH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

    state_t state_reg;
    state_t state_next;

    // Operation held for the duration of a transaction.
    logic [1:0]         mode_reg;
    logic [KW-1:0]      key_reg;
    logic [BW-1:0]      bucket_reg;
    logic [KW-1:0]      quot_reg;
    logic [BW-1:0]      clr_reg;
    logic               report_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;

    // Result registers.
    logic               done_reg;
    logic               hit_reg;
    logic               full_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [KEY_PORT_W-1:0] key_m;
    logic                  accept;
    logic                  clr_last;

    // Memory ports.
    logic                  rd_en;
    logic [BW-1:0]         rd_addr;
    logic                  keys_we;
    logic                  valid_we;
    logic [BW-1:0]         wr_addr;
    logic [SLOTS*KW-1:0]   keys_rd;
    logic [SLOTS*KW-1:0]   keys_wr;
    logic [SLOTS-1:0]      valid_rd;
    logic [SLOTS-1:0]      valid_wr;

    // Row update.
    logic [SLOTS-1:0]      match;
    logic [SLOTS-1:0]      free;
    logic [SLOTS-1:0]      first_free;
    logic                  row_hit;
    logic                  row_has_free;
    logic                  do_insert;
    logic                  do_delete;
    logic                  refuse;

    // Bucket by reciprocal multiplication.
    logic [PW-1:0]         recip_prod;
    logic [KW-1:0]         rem_full;
    logic [BW-1:0]         row_mod;

    assign key_m    = key & KEY_MASK;
    assign accept   = start && !busy;
    assign clr_last = (clr_reg == LAST_ROW);

    // Key slots hold one key per slot; the row is written whole.
    bhs_ram #(
        .WIDTH (SLOTS * KW),
        .DEPTH (BUCKETS)
    ) u_keys_ram (
        .clk   (clk),
        .we    (keys_we),
        .waddr (wr_addr),
        .wdata (keys_wr),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (keys_rd)
    );

    // One valid bit per slot; cleared row by row after reset and on clear all.
    bhs_ram #(
        .WIDTH (SLOTS),
        .DEPTH (BUCKETS)
    ) u_valid_ram (
        .clk   (clk),
        .we    (valid_we),
        .waddr (wr_addr),
        .wdata (valid_wr),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (valid_rd)
    );

    // The quotient is registered in ST_HASH; the remainder follows from it in
    // ST_READ, as the row is read.
    assign recip_prod = PW'(key_reg) * PW'(RECIP);
    assign rem_full   = key_reg - KW'(quot_reg * KW'(BUCKETS));
    assign row_mod    = BW'(rem_full);

    // Compare every slot of the row against the key and find the lowest free
    // slot. Valid bits guard the compare, so a key slot never written is
    // never trusted. At most one slot can match, which keeps delete simple.
    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            match[s] = valid_rd[s] && (keys_rd[s*KW +: KW] == key_reg);
        end
        free         = ~valid_rd;
        first_free   = free & SLOTS'(~free + SLOTS'(1));
        row_hit      = |match;
        row_has_free = |free;
        do_insert    = (mode_reg == MODE_INSERT) && !row_hit && row_has_free;
        refuse       = (mode_reg == MODE_INSERT) && !row_hit && !row_has_free;
        do_delete    = (mode_reg == MODE_DELETE) && row_hit;
        for (int s = 0; s < SLOTS; s++)
        begin
            keys_wr[s*KW +: KW] = first_free[s] ? key_reg : keys_rd[s*KW +: KW];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_CLEAR)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if (IS_POW2)
                    begin
                        state_next = ST_UPDATE;
                    end
                    else
                    begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: handshake, memory controls and count update.
    always_comb
    begin
        busy       = 1'b1;
        rd_en      = 1'b0;
        rd_addr    = bucket_reg;
        keys_we    = 1'b0;
        valid_we   = 1'b0;
        wr_addr    = bucket_reg;
        valid_wr   = valid_rd;
        total_next = total_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy    = 1'b0;
                // With a power-of-two bucket count the row is read as the
                // operation is taken.
                rd_en   = IS_POW2 && accept && (mode != MODE_CLEAR);
                rd_addr = key_m[BW-1:0];
            end
            ST_HASH:
            begin
            end
            ST_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = row_mod;
            end
            ST_UPDATE:
            begin
                if (do_insert)
                begin
                    keys_we    = 1'b1;
                    valid_we   = 1'b1;
                    valid_wr   = valid_rd | first_free;
                    total_next = total_reg + COUNT_W'(1);
                end
                else if (do_delete)
                begin
                    valid_we   = 1'b1;
                    valid_wr   = valid_rd & ~match;
                    total_next = total_reg - COUNT_W'(1);
                end
            end
            ST_CLEAR:
            begin
                valid_we   = 1'b1;
                wr_addr    = clr_reg;
                valid_wr   = '0;
                total_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Control state; reset starts the clearing pass without a result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            report_reg <= 1'b0;
            total_reg  <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            done_reg  <= (state_reg == ST_UPDATE) ||
                         ((state_reg == ST_CLEAR) && clr_last && report_reg);
            if (state_reg == ST_IDLE && accept)
            begin
                clr_reg    <= '0;
                report_reg <= 1'b1;
            end
            else if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + BW'(1);
            end
        end
    end

    // Transaction payload and the bucket computation.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept)
        begin
            mode_reg   <= mode;
            key_reg    <= key_m[KW-1:0];
            bucket_reg <= key_m[BW-1:0];
        end
        else if (state_reg == ST_HASH)
        begin
            quot_reg <= KW'(recip_prod >> QSH);
        end
        else if (state_reg == ST_READ)
        begin
            bucket_reg <= row_mod;
        end

        if (state_reg == ST_UPDATE)
        begin
            hit_reg   <= row_hit;
            full_reg  <= refuse;
            count_reg <= total_next;
        end
        else if (state_reg == ST_CLEAR)
        begin
            hit_reg   <= 1'b0;
            full_reg  <= 1'b0;
            count_reg <= '0;
        end
    end

    assign done         = done_reg;
    assign hit          = hit_reg;
    assign full_res     = full_reg;
    assign stored_count = count_reg;

endmodule : bucketed_hash_set_unit

// File: tb/sv/bhs_reply_checker.sv
`timescale 1ns / 1ps
// Checker for the bucketed hash set: predicts each reply and compares it with the block.
module bhs_reply_checker #(
    parameter int unsigned BUCKETS          = 16,
    parameter int unsigned SLOTS_PER_BUCKET = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [1:0]                      mode,
    input  logic [bhs_pkg::KEY_PORT_W-1:0]  key,
    input  logic                            done,
    input  logic                            hit,
    input  logic                            full_res,
    input  logic [bhs_pkg::COUNT_W-1:0]     stored_count,
    output int                              failures,
    output int                              outstanding
);
    import bhs_pkg::*;

    localparam int unsigned TOTAL_SLOTS = BUCKETS * SLOTS_PER_BUCKET;

    typedef struct packed {
        logic               hit;
        logic               full;
        logic [COUNT_W-1:0] count;
    } set_reply_t;

    logic [KEY_PORT_W-1:0] slot_key [TOTAL_SLOTS];
    bit                    slot_used [TOTAL_SLOTS];
    logic [COUNT_W-1:0]    key_total = '0;
    set_reply_t            reply_q [$];
    set_reply_t            oldest_reply;
    int                    fail_cnt = 0;

    initial
    begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        failures    = 0;
        outstanding = 0;
    end

    // Applies one operation to the shadow set and returns the reply it gives.
    function automatic set_reply_t apply_set_op(mode_t op, logic [KEY_PORT_W-1:0] k);
        int unsigned base;
        int          found;
        int          free_slot;
        set_reply_t  r;
        base      = (k % BUCKETS) * SLOTS_PER_BUCKET;
        found     = -1;
        free_slot = -1;
        r         = '0;
        if (op == MODE_CLEAR)
        begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            key_total = '0;
        end
        else
        begin
            for (int s = 0; s < SLOTS_PER_BUCKET; s++)
            begin
                if (slot_used[base + s] && slot_key[base + s] == k && found < 0)
                    found = base + s;
                if (!slot_used[base + s] && free_slot < 0)
                    free_slot = base + s;
            end
            r.hit = (found >= 0);
            if (op == MODE_INSERT && !r.hit)
            begin
                if (free_slot < 0)
                    r.full = 1'b1;
                else
                begin
                    slot_key[free_slot]  = k;
                    slot_used[free_slot] = 1'b1;
                    key_total            = key_total + COUNT_W'(1);
                end
            end
            else if (op == MODE_DELETE && r.hit)
            begin
                slot_used[found] = 1'b0;
                key_total        = key_total - COUNT_W'(1);
            end
        end
        r.count = key_total;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // The reply of an operation never appears at the edge that accepts it,
            // so replies are retired before the new prediction is queued.
            if (done)
            begin
                if (reply_q.size() == 0)
                begin
                    if (fail_cnt < 10)
                        $display("%0t: reply with none pending: hit=%0b full=%0b count=%0d",
                                 $time, hit, full_res, stored_count);
                    fail_cnt++;
                end
                else
                begin
                    oldest_reply = reply_q.pop_front();
                    if (oldest_reply.hit !== hit || oldest_reply.full !== full_res
                        || oldest_reply.count !== stored_count)
                    begin
                        if (fail_cnt < 10)
                            $display("%0t: reply mismatch: expected hit=%0b full=%0b count=%0d, got hit=%0b full=%0b count=%0d",
                                     $time, oldest_reply.hit, oldest_reply.full,
                                     oldest_reply.count, hit, full_res, stored_count);
                        fail_cnt++;
                    end
                end
            end
            if (start && !busy)
                reply_q.push_back(apply_set_op(mode_t'(mode), key));
        end
        failures    <= fail_cnt;
        outstanding <= reply_q.size();
    end

endmodule : bhs_reply_checker

// File: tb/sv/tb_bucketed_hash_set_unit.sv
`timescale 1ns / 1ps
// Testbench top for the bucketed hash set: stimulus, timeout and verdict.
//
// The top only drives operations into the block; the checker beside it
// watches both channels, keeps its own copy of the set and compares every
// reply. The run has a directed part, a pass that fills the whole table, and
// three random phases with different amounts of sender idling.
module tb_bucketed_hash_set_unit;
    import bhs_pkg::*;

    localparam int unsigned BUCKETS          = 16;
    localparam int unsigned SLOTS_PER_BUCKET = 8;
    localparam int unsigned POOL_SIZE        = 30;
    localparam int unsigned PHASE_OPS        = 330;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            mode;
    logic [KEY_PORT_W-1:0] key;
    logic                  done;
    logic                  hit;
    logic                  full_res;
    logic [COUNT_W-1:0]    stored_count;
    int                    failures;
    int                    outstanding;

    // Percentage of transactions after which the sender goes quiet for a while.
    int unsigned           gap_pct;
    int unsigned           ops_sent;
    logic [KEY_PORT_W-1:0] key_pool [POOL_SIZE];

    bucketed_hash_set_unit #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
        .KEY_BITS         (32)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .key          (key),
        .done         (done),
        .hit          (hit),
        .full_res     (full_res),
        .stored_count (stored_count)
    );

    bhs_reply_checker #(
        .BUCKETS          (BUCKETS),
        .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .key          (key),
        .done         (done),
        .hit          (hit),
        .full_res     (full_res),
        .stored_count (stored_count),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // A generous ceiling on the whole run; a hung handshake ends up here.
    initial
    begin
        #5_000_000;
        $display("tb_bucketed_hash_set_unit failed");
        $finish;
    end

    // Presents one operation and holds it until the block accepts it. The
    // task returns at the accepting edge, or after a random idle gap with start
    // low; without a gap a following call can keep start high throughout.
    task automatic issue_op(mode_t op, logic [KEY_PORT_W-1:0] k);
        start <= 1'b1;
        mode  <= op;
        key   <= k;
        do @(posedge clk); while (busy);
        ops_sent++;
        if ($urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Stops sending and waits until the checker has seen every reply. The
    // outstanding count is one edge old when read, hence the edge first.
    task automatic wait_for_replies(int unsigned limit);
        int unsigned waited;
        waited = 0;
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < limit);
    endtask

    // Draws a fresh pool of keys crowded into at most three buckets, so that buckets
    // fill up, keys get re-inserted and deletes find what they look for.
    task automatic refresh_pool();
        logic [3:0] hot [3];
        foreach (hot[i]) hot[i] = 4'($urandom_range(0, BUCKETS - 1));
        foreach (key_pool[i]) key_pool[i] = {28'($urandom()), hot[$urandom_range(0, 2)]};
    endtask

    // Random phase: mostly bursts of operations on the key pool, with some
    // fully random transactions thrown in as noise.
    task automatic run_random_phase(int unsigned n_ops);
        int unsigned target;
        int unsigned pick;
        int unsigned burst;
        target = ops_sent + n_ops;
        refresh_pool();
        while (ops_sent < target)
        begin
            if ($urandom_range(99) < 70)
            begin
                if ($urandom_range(3) == 0)
                    refresh_pool();
                burst = $urandom_range(8, 24);
                repeat (burst)
                begin
                    pick = $urandom_range(99);
                    if (pick < 45)
                        issue_op(MODE_INSERT, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
                    else if (pick < 65)
                        issue_op(MODE_DELETE, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
                    else if (pick < 97)
                        issue_op(MODE_LOOKUP, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
                    else
                        issue_op(MODE_CLEAR, $urandom());
                end
            end
            else if ($urandom_range(19) == 0)
                issue_op(MODE_CLEAR, $urandom());
            else
                issue_op(mode_t'($urandom_range(0, 2)), $urandom());
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        mode     = MODE_LOOKUP;
        key      = '0;
        gap_pct  = 17;
        ops_sent = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: key extremes, a repeated insert, a bucket filled to
        // the brim and then overrun, a delete of an absent key into that full
        // bucket, a delete that succeeds, and a clear whose key is ignored.
        issue_op(MODE_INSERT, 32'h0000_0000);
        issue_op(MODE_INSERT, 32'hFFFF_FFFF);
        issue_op(MODE_INSERT, 32'h0000_0000);
        issue_op(MODE_LOOKUP, 32'hFFFF_FFFF);
        for (int i = 0; i < SLOTS_PER_BUCKET; i++)
            issue_op(MODE_INSERT, (i << 28) | 32'h0ABC_DEF5);
        issue_op(MODE_INSERT, 32'hF0AB_CDE5);
        issue_op(MODE_INSERT, 32'h3ABC_DEF5);
        issue_op(MODE_DELETE, 32'h7777_7775);
        issue_op(MODE_DELETE, 32'h0000_0000);
        issue_op(MODE_LOOKUP, 32'h0000_0000);
        issue_op(MODE_CLEAR, 32'hA5A5_5A5A);
        issue_op(MODE_LOOKUP, 32'hFFFF_FFFF);
        issue_op(MODE_INSERT, 32'hFFFF_FFFF);

        // Fill every bucket, with one refused insert per bucket, so the count
        // climbs all the way to a full table.
        issue_op(MODE_CLEAR, $urandom());
        for (int b = 0; b < BUCKETS; b++)
            for (int s = 0; s <= SLOTS_PER_BUCKET; s++)
                issue_op(MODE_INSERT, {28'($urandom()), 4'(b)});

        // The sender holds back here until every reply so far has come in.
        wait_for_replies(2000);
        run_random_phase(PHASE_OPS);
        wait_for_replies(2000);
        gap_pct = 46;
        run_random_phase(PHASE_OPS);
        wait_for_replies(2000);
        gap_pct = 0;
        run_random_phase(PHASE_OPS);

        // A clear sweeps one bucket per cycle, so the wait after the last reply
        // below is ample for any stray result to show up.
        wait_for_replies(4000);
        repeat (3 * BUCKETS) @(posedge clk);
        if (outstanding != 0)
            $display("replies still outstanding at the end: %0d", outstanding);
        if (failures == 0 && outstanding == 0)
            $display("tb_bucketed_hash_set_unit passed");
        else
            $display("tb_bucketed_hash_set_unit failed");
        $finish;
    end

endmodule : tb_bucketed_hash_set_unit

// File: bucketed_hash_set_unit.f
hdl/bhs_pkg.sv
hdl/bhs_ram.sv
hdl/bucketed_hash_set_unit.sv
tb/sv/bhs_reply_checker.sv
tb/sv/tb_bucketed_hash_set_unit.sv
